@@ design/lsfp_pkg.sv @@
package lsfp_pkg;

  localparam int PacketsPerFrameDef = 60;

  localparam logic [7:0] SYNC0 = 8'hFA;
  localparam logic [7:0] SYNC1 = 8'hA0;

  localparam logic [5:0] PACKET_LAST   = 6'd41;
  localparam logic [5:0] SPEED_LO_POS  = 6'd2;
  localparam logic [5:0] SPEED_HI_POS  = 6'd3;
  localparam logic [5:0] READING_FIRST = 6'd4;
  localparam logic [5:0] READING_END   = 6'd40;
  localparam logic [2:0] READING_LEN   = 3'd6;

  localparam logic [2:0] K_STR_LO  = 3'd0;
  localparam logic [2:0] K_STR_HI  = 3'd1;
  localparam logic [2:0] K_DIST_LO = 3'd2;
  localparam logic [2:0] K_DIST_HI = 3'd3;

  localparam logic [8:0] TOP_ANGLE = 9'd359;

  // Division by ten of a 16-bit word: (x * 52429) >> 19 is exact over the range.
  localparam logic [16:0] RPM_RECIP = 17'd52429;
  localparam int          RPM_SHIFT = 19;

  // Division by six for offsets below 36: (x * 43) >> 8 is exact there.
  localparam logic [5:0] SLOT_RECIP = 6'd43;

  typedef struct packed {
    logic [8:0]  angle;
    logic [15:0] distance;
    logic [15:0] strength;
    logic [12:0] rpm;
    logic        frame_done;
  } result_t;

endpackage

@@ design/lsfp_byte_if.sv @@
interface lsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ design/lsfp_result_if.sv @@
interface lsfp_result_if;
  logic        valid;
  logic        ready;
  logic [8:0]  angle;
  logic [15:0] distance;
  logic [15:0] strength;
  logic [12:0] rpm;
  logic        frame_done;

  modport source (
    output valid, output angle, output distance, output strength,
    output rpm, output frame_done, input ready
  );
  modport sink (
    input valid, input angle, input distance, input strength,
    input rpm, input frame_done, output ready
  );
endinterface

@@ design/lidar_scan_frame_parser_unit.sv @@
// Scan frame parser for a rotating laser range sensor.
// The byte_ch channel carries one received serial byte per item. The
// parser hunts for the sync pair 0xFA, 0xA0, then follows a frame of
// PACKETS_PER_FRAME packets of 42 bytes. Each packet whose header matches
// yields six readings on result_ch (angle, distance, strength, rpm), and
// the last byte of the frame yields one item with frame_done set and all
// other fields zero, after which the hunt resumes.
// One byte is accepted every cycle while byte_ch is ready. A result is
// registered when the byte that completes it is accepted. The running state
// and the rpm divider (a reciprocal multiply) sit in one register stage.
// The result side has a two-entry buffer, so byte_ch stays ready while one
// result waits; it drops ready only when both entries are full, and
// resumes as soon as the receiver takes an item.
// Synchronous reset returns the parser to hunting and empties the
// result buffer.
module lidar_scan_frame_parser_unit
  import lsfp_pkg::*;
#(
  parameter int PACKETS_PER_FRAME = PacketsPerFrameDef
) (
  input  logic                 clk,
  input  logic                 rst,
  lsfp_byte_if.sink            byte_ch,
  lsfp_result_if.source        result_ch
);

  typedef enum logic [2:0] {
    SEEK_SYNC0 = 3'b001,
    SEEK_SYNC1 = 3'b010,
    IN_FRAME   = 3'b100
  } phase_t;

  phase_t       phase, phase_next;
  logic [5:0]   byte_position, byte_position_next;
  logic [5:0]   packet_number, packet_number_next;
  logic         packet_good, packet_good_next;
  logic [7:0]   speed_low, speed_low_next;
  logic [12:0]  rpm_held, rpm_held_next;
  logic [15:0]  strength_held, strength_held_next;
  logic [7:0]   distance_low, distance_low_next;

  result_t      head, skid, res;
  logic         head_valid, skid_valid;
  logic         res_valid;

  logic         accept, pop, push;
  logic [7:0]   b;
  logic [5:0]   rel;
  logic [10:0]  rel_scaled;
  logic [2:0]   slot;
  logic [2:0]   k;
  logic [32:0]  rpm_prod;
  logic [8:0]   idx;
  logic [6:0]   pn_inc;

  assign b      = byte_ch.byte_in;
  assign accept = byte_ch.valid && byte_ch.ready;
  assign pop    = head_valid && result_ch.ready;
  assign push   = accept && res_valid;

  assign rel        = byte_position - READING_FIRST;
  assign rel_scaled = 11'(rel) * 11'(SLOT_RECIP);
  assign slot       = rel_scaled[10:8];
  assign k          = 3'(rel - 6'(slot) * 6'(READING_LEN));
  assign rpm_prod   = 33'({b, speed_low}) * 33'(RPM_RECIP);
  assign idx        = 9'({packet_number, 2'b00}) + 9'({packet_number, 1'b0}) + 9'(slot);
  assign pn_inc     = 7'(packet_number) + 7'd1;

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    packet_number_next = packet_number;
    packet_good_next   = packet_good;
    speed_low_next     = speed_low;
    rpm_held_next      = rpm_held;
    strength_held_next = strength_held;
    distance_low_next  = distance_low;
    res_valid          = 1'b0;
    res                = '0;

    unique case (phase)
      SEEK_SYNC1: begin
        if (b == SYNC1) begin
          phase_next         = IN_FRAME;
          byte_position_next = SPEED_LO_POS;
          packet_number_next = '0;
          packet_good_next   = 1'b1;
        end else begin
          phase_next = SEEK_SYNC0;
        end
      end
      IN_FRAME: begin
        if (byte_position == 6'd0) begin
          packet_good_next = (b == SYNC0);
        end else if (byte_position == 6'd1) begin
          packet_good_next = packet_good && (b == SYNC1 + 8'(packet_number));
        end else if (byte_position == SPEED_LO_POS) begin
          speed_low_next = b;
        end else if (byte_position == SPEED_HI_POS) begin
          if (packet_good) begin
            rpm_held_next = rpm_prod[RPM_SHIFT +: 13];
          end
        end else if (byte_position < READING_END) begin
          if (k == K_STR_LO) begin
            strength_held_next = {8'd0, b};
          end else if (k == K_STR_HI) begin
            strength_held_next = {b, strength_held[7:0]};
          end else if (k == K_DIST_LO) begin
            distance_low_next = b;
          end else if (k == K_DIST_HI && packet_good) begin
            res_valid    = 1'b1;
            res.angle    = TOP_ANGLE - idx;
            res.distance = {b, distance_low};
            res.strength = strength_held;
            res.rpm      = rpm_held;
          end
        end

        if (byte_position >= PACKET_LAST) begin
          byte_position_next = '0;
          if (pn_inc >= 7'(PACKETS_PER_FRAME)) begin
            res_valid          = 1'b1;
            res                = '0;
            res.frame_done     = 1'b1;
            phase_next         = SEEK_SYNC0;
            packet_number_next = '0;
            packet_good_next   = 1'b0;
          end else begin
            packet_number_next = pn_inc[5:0];
          end
        end else begin
          byte_position_next = byte_position + 6'd1;
        end
      end
      default: begin
        phase_next = (b == SYNC0) ? SEEK_SYNC1 : SEEK_SYNC0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= SEEK_SYNC0;
      byte_position <= '0;
      packet_number <= '0;
      packet_good   <= 1'b0;
      speed_low     <= '0;
      rpm_held      <= '0;
      strength_held <= '0;
      distance_low  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      packet_number <= packet_number_next;
      packet_good   <= packet_good_next;
      speed_low     <= speed_low_next;
      rpm_held      <= rpm_held_next;
      strength_held <= strength_held_next;
      distance_low  <= distance_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= res;
        end else begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        head <= res;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid) begin
        head       <= res;
        head_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign byte_ch.ready        = !skid_valid;
  assign result_ch.valid      = head_valid;
  assign result_ch.angle      = head.angle;
  assign result_ch.distance   = head.distance;
  assign result_ch.strength   = head.strength;
  assign result_ch.rpm        = head.rpm;
  assign result_ch.frame_done = head.frame_done;

endmodule

@@ design/lsfp_checker.sv @@
module lsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  angle,
  input logic [15:0] distance,
  input logic [15:0] strength,
  input logic [12:0] rpm,
  input logic        frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> angle == 9'd0 && distance == 16'd0 &&
      strength == 16'd0 && rpm == 13'd0)
    else $error("frame-done item carries nonzero fields");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> angle <= 9'd359 && rpm <= 13'd6553)
    else $error("reading item out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result buffer not empty after reset");

endmodule

bind lidar_scan_frame_parser_unit lsfp_checker u_lsfp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (byte_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .angle      (result_ch.angle),
  .distance   (result_ch.distance),
  .strength   (result_ch.strength),
  .rpm        (result_ch.rpm),
  .frame_done (result_ch.frame_done)
);
